### design/ffkc_pkg.sv
// ----------------------------------------------------------------------------
// ffkc_pkg: shared types and constants for the keypad calculator
// Key codes, operator codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package ffkc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int INT_BITS_DEF  = 32;

  typedef enum logic [1:0] {
    KIND_DIGIT = 2'd0,
    KIND_OP    = 2'd1,
    KIND_EQ    = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NONE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ITER,
    ST_FINISH,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the key and set up operands
    logic step;    // one iteration of the shift/add or shift/subtract unit
    logic finish;  // saturate and commit the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic iterate; // the loaded key needs the iterative unit
    logic last;    // current iteration is the final one
  } status_t;

endpackage

### design/ffkc_ctrl.sv
// ----------------------------------------------------------------------------
// ffkc_ctrl: controller for the keypad calculator
// Sequences load, iteration and commit, and runs the stream handshakes.
// ----------------------------------------------------------------------------
module ffkc_ctrl
  import ffkc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.iterate) begin
          state_next = ST_ITER;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_ITER: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/ffkc_dp.sv
// ----------------------------------------------------------------------------
// ffkc_dp: datapath for the keypad calculator
// Holds calculator state; a shared sign/magnitude unit adds, multiplies
// bit-serially and divides by restoring steps, then saturates.
// ----------------------------------------------------------------------------
module ffkc_dp
  import ffkc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int INT_BITS  = INT_BITS_DEF,
  localparam int W        = INT_BITS + FRAC_BITS
)(
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    kind,
  input  logic [3:0]    digit,
  input  logic [1:0]    op_code,
  input  cmd_t          cmd,
  output status_t       status,
  output logic [W-1:0]  display,
  output logic          overflow,
  output logic          div_error
);

  // Multiply: W iterations over the multiplier bits, accumulator 2W+1 bits.
  // Divide: W+FRAC_BITS iterations over the numerator bits.
  localparam int NB   = W + FRAC_BITS;
  localparam int ACCW = 2 * W + 1;
  localparam int CW   = $clog2(NB + 1);

  logic signed [W-1:0] disp_val, prev_val, const_val;
  op_t                 pend_op;
  logic                restart, repeating;

  logic [1:0]          k;
  logic [3:0]          dg;
  op_t                 eop;
  logic                neg;
  logic [W:0]          ma, mb;        // magnitudes (W+1 bits for -2^(W-1))
  logic [ACCW-1:0]     acc;           // product, sum or quotient magnitude
  logic [NB-1:0]       num;           // numerator shift register / multiplier
  logic [W+1:0]        rem;
  logic [CW-1:0]       cnt;
  logic                zero_div;
  logic                iter;

  logic signed [W-1:0] x, y;
  logic [W:0]          dmag;
  logic [W+4:0]        dx10;
  logic [ACCW-1:0]     dval;

  function automatic logic [W:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
  endfunction

  always_comb begin
    x = previous_sel(1'b1);
    y = previous_sel(1'b0);
  end

  function automatic logic signed [W-1:0] previous_sel(input logic first);
    logic swap;
    swap = (pend_op == OP_ADD) || (pend_op == OP_MUL);
    if (!repeating) begin
      previous_sel = first ? prev_val : disp_val;
    end else if (swap) begin
      previous_sel = first ? const_val : disp_val;
    end else begin
      previous_sel = first ? disp_val : const_val;
    end
  endfunction

  assign dmag = mag(disp_val);
  assign dx10 = ({4'd0, dmag} << 3) + ({4'd0, dmag} << 1);
  assign dval = ACCW'(digit) << FRAC_BITS;

  assign status.iterate = iter;
  assign status.last    = (eop == OP_MUL) ? (cnt == CW'(W - 1)) : (cnt == CW'(NB - 1));

  // Saturation of sign/magnitude acc
  logic [ACCW-1:0] lim;
  logic [ACCW-1:0] macc;
  logic            sat;
  logic [W-1:0]    satv;
  always_comb begin
    macc = (eop == OP_MUL) ? (acc >> FRAC_BITS) : acc;
    lim  = ACCW'(1) << (W - 1);
    if (!neg) lim = lim - 1'b1;
    sat  = macc > lim;
    if (sat) macc = lim;
    satv = neg ? W'(~macc + 1'b1) : W'(macc);
  end

  logic [W+1:0] rsh;
  always_comb begin
    rsh = {rem[W:0], num[NB-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_val  <= '0;
      prev_val  <= '0;
      const_val <= '0;
      pend_op   <= OP_NONE;
      restart   <= 1'b0;
      repeating <= 1'b0;
      overflow  <= 1'b0;
      div_error <= 1'b0;
      iter      <= 1'b0;
      k         <= KIND_DIGIT;
    end else if (cmd.load) begin
      k         <= kind;
      dg        <= digit;
      overflow  <= 1'b0;
      div_error <= 1'b0;
      iter      <= 1'b0;
      cnt       <= '0;
      rem       <= '0;
      zero_div  <= 1'b0;
      case (kind_t'(kind))
        KIND_DIGIT: begin
          eop <= OP_ADD;
          ma  <= dmag;
          // display*10 + digit as sign/magnitude
          if (!disp_val[W-1]) begin
            neg <= 1'b0;
            acc <= ACCW'(dx10) + dval;
          end else if (ACCW'(dx10) >= dval) begin
            neg <= 1'b1;
            acc <= ACCW'(dx10) - dval;
          end else begin
            neg <= 1'b0;
            acc <= dval - ACCW'(dx10);
          end
        end
        KIND_OP: begin
          pend_op  <= op_t'({1'b0, op_code});
          prev_val <= disp_val;
          restart  <= 1'b1;
        end
        KIND_EQ: begin
          if (!repeating) const_val <= disp_val;
          eop <= pend_op;
          ma  <= mag(x);
          mb  <= mag(y);
          neg <= x[W-1] ^ y[W-1];
          acc <= '0;
          case (pend_op)
            OP_ADD, OP_SUB: begin
              if (x[W-1] == (y[W-1] ^ (pend_op == OP_SUB))) begin
                neg <= x[W-1];
                acc <= ACCW'(mag(x)) + ACCW'(mag(y));
              end else if (mag(x) >= mag(y)) begin
                neg <= x[W-1];
                acc <= ACCW'(mag(x) - mag(y));
              end else begin
                neg <= ~x[W-1];
                acc <= ACCW'(mag(y) - mag(x));
              end
            end
            OP_MUL: begin
              iter <= 1'b1;
              num  <= NB'(mag(y));
            end
            OP_DIV: begin
              if (y == '0) begin
                zero_div <= 1'b1;
              end else begin
                iter <= 1'b1;
                num  <= NB'(mag(x)) << FRAC_BITS;
              end
            end
            default: begin
              neg <= 1'b0;
            end
          endcase
        end
        default: begin
          disp_val  <= '0;
          prev_val  <= '0;
          const_val <= '0;
          pend_op   <= OP_NONE;
          restart   <= 1'b0;
          repeating <= 1'b0;
        end
      endcase
    end else if (cmd.step) begin
      cnt <= cnt + 1'b1;
      if (eop == OP_MUL) begin
        // multiplier LSB first; acc shifts right, add at top
        num <= num >> 1;
        if (num[0]) begin
          acc <= (acc + (ACCW'(ma) << W)) >> 1;
        end else begin
          acc <= acc >> 1;
        end
      end else begin
        num <= num << 1;
        if (rsh >= {1'b0, mb}) begin
          rem <= rsh - {1'b0, mb};
          acc <= {acc[ACCW-2:0], 1'b1};
        end else begin
          rem <= rsh;
          acc <= {acc[ACCW-2:0], 1'b0};
        end
      end
    end else if (cmd.finish) begin
      case (kind_t'(k))
        KIND_DIGIT: begin
          if (dg <= 4'd9) begin
            repeating <= 1'b0;
            if (restart || disp_val == '0) begin
              disp_val <= W'(dg) << FRAC_BITS;
              restart  <= 1'b0;
            end else begin
              disp_val <= satv;
              overflow <= sat;
            end
          end
        end
        KIND_EQ: begin
          prev_val  <= disp_val;
          repeating <= 1'b1;
          if (eop == OP_NONE) begin
            disp_val <= '0;
          end else if (zero_div) begin
            disp_val  <= '0;
            div_error <= 1'b1;
          end else begin
            disp_val <= satv;
            overflow <= sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign display = disp_val;

endmodule

### design/four_function_keypad_calculator.sv
// ----------------------------------------------------------------------------
// four_function_keypad_calculator: keypad calculator with constant repeat
// Takes one key per transaction and returns the display with flags.
// ----------------------------------------------------------------------------
// channel   dir  tdata bits (low first)                  tuser
// s_axis    in   [1:0] kind, [5:2] digit, [7:6] op_code  -
// m_axis    out  [47:0] display, [48] overflow,
//                [49] div_error (56 bits)                 -
//
// One key at a time. Every key passes through the load, execute, commit
// and output states; multiply and divide also iterate in the bit-serial
// shift/add and restoring-divide unit between execute and commit. Reset
// clears the display and all operands. A stalled result holds the block;
// no new key is taken until it is delivered.
// ----------------------------------------------------------------------------
module four_function_keypad_calculator
  import ffkc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int INT_BITS  = INT_BITS_DEF
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // kind[1:0], digit[5:2], op_code[7:6]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [((INT_BITS + FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata
                                     // display, overflow, div_error, zero fill
);

  localparam int W  = INT_BITS + FRAC_BITS;
  localparam int OW = ((W + 2 + 7) / 8) * 8;

  cmd_t         cmd;
  status_t      status;
  logic [W-1:0] display;
  logic         overflow, div_error;

  // Sequence the key through load, iterate, commit and output
  ffkc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  ffkc_dp #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .kind      (s_axis_tdata[1:0]),
    .digit     (s_axis_tdata[5:2]),
    .op_code   (s_axis_tdata[7:6]),
    .cmd       (cmd),
    .status    (status),
    .display   (display),
    .overflow  (overflow),
    .div_error (div_error)
  );

  // Pack the result; zero-fill to a whole byte
  assign m_axis_tdata = OW'({div_error, overflow, display});

endmodule

### test/tb_four_function_keypad_calculator.sv
// ----------------------------------------------------------------------------
// tb_four_function_keypad_calculator: keypad calculator testbench
// Drives key transactions with random idling on both streams and compares
// every displayed value and flag with a fixed-point calculator model.
// ----------------------------------------------------------------------------
class ffkc_scoreboard;
  localparam int W = 48;
  localparam int FB = 16;

  // Packed from the top bit down: div_error[49], overflow[48], display[47:0]
  typedef struct packed {
    logic        div_error;
    logic        overflow;
    logic [47:0] display;
  } result_t;

  logic signed [47:0] disp_r, prev_r, const_r;
  ffkc_pkg::op_t      op_r;
  bit                 restart_r, repeat_r;
  result_t            pending_q[$];
  int                 errors, checked, ovf_seen, derr_seen;

  function new();
    errors = 0;
    checked = 0;
    ovf_seen = 0;
    derr_seen = 0;
    clear_state();
  endfunction

  function void clear_state();
    disp_r = '0;
    prev_r = '0;
    const_r = '0;
    op_r = ffkc_pkg::OP_NONE;
    restart_r = 0;
    repeat_r = 0;
  endfunction

  // Clamp an exact wide value into the display range.
  function logic signed [47:0] clamp(logic signed [127:0] v, inout bit ovf);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (W - 1)) - 1;
    lo = -(128'sd1 <<< (W - 1));
    if (v > hi) begin
      ovf = 1;
      return hi[47:0];
    end
    if (v < lo) begin
      ovf = 1;
      return lo[47:0];
    end
    return v[47:0];
  endfunction

  // Apply one arithmetic operation; multiply and divide truncate toward zero.
  function logic signed [47:0] calc(ffkc_pkg::op_t op, logic signed [47:0] a,
                                    logic signed [47:0] b, inout bit ovf,
                                    inout bit derr);
    logic signed [127:0] wa, wb, r;
    bit neg;
    wa = a;
    wb = b;
    neg = (a < 0) != (b < 0);
    case (op)
      ffkc_pkg::OP_ADD: r = wa + wb;
      ffkc_pkg::OP_SUB: r = wa - wb;
      ffkc_pkg::OP_MUL: begin
        r = ((wa < 0 ? -wa : wa) * (wb < 0 ? -wb : wb)) >> FB;
        if (neg) r = -r;
      end
      ffkc_pkg::OP_DIV: begin
        if (b == 0) begin
          derr = 1;
          return '0;
        end
        r = ((wa < 0 ? -wa : wa) << FB) / (wb < 0 ? -wb : wb);
        if (neg) r = -r;
      end
      default: return '0;
    endcase
    return clamp(r, ovf);
  endfunction

  // Note an accepted key and queue the display it should produce.
  function void note_key(logic [1:0] kind, logic [3:0] dig, logic [1:0] opc);
    bit ovf, derr;
    logic signed [47:0] x, y, res;
    logic signed [127:0] t;
    ovf = 0;
    derr = 0;
    case (ffkc_pkg::kind_t'(kind))
      ffkc_pkg::KIND_DIGIT: begin
        if (dig <= 9) begin
          repeat_r = 0;
          if (restart_r || disp_r == 0) begin
            disp_r = 48'(dig) << FB;
            restart_r = 0;
          end else begin
            t = disp_r;
            t = t * 10 + (128'(dig) << FB);
            disp_r = clamp(t, ovf);
          end
        end
      end
      ffkc_pkg::KIND_OP: begin
        op_r = ffkc_pkg::op_t'({1'b0, opc});
        prev_r = disp_r;
        restart_r = 1;
      end
      ffkc_pkg::KIND_EQ: begin
        if (!repeat_r) begin
          const_r = disp_r;
          x = prev_r;
          y = disp_r;
        end else if (op_r == ffkc_pkg::OP_ADD || op_r == ffkc_pkg::OP_MUL) begin
          x = const_r;
          y = disp_r;
        end else begin
          x = disp_r;
          y = const_r;
        end
        res = calc(op_r, x, y, ovf, derr);
        prev_r = disp_r;
        disp_r = res;
        repeat_r = 1;
      end
      default: clear_state();
    endcase
    ovf_seen += ovf;
    derr_seen += derr;
    pending_q.push_back('{display: disp_r, overflow: ovf, div_error: derr});
  endfunction

  // Compare one delivered result with the oldest expectation.
  function void check_result(logic [55:0] data);
    result_t got, want;
    got = data[49:0];
    checked++;
    if (pending_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result %h", $time, got);
      return;
    end
    want = pending_q.pop_front();
    if (got.display !== want.display) begin
      errors++;
      $display("%0t: display expected %h actual %h", $time, want.display, got.display);
    end
    if (got.overflow !== want.overflow) begin
      errors++;
      $display("%0t: overflow expected %b actual %b", $time, want.overflow,
               got.overflow);
    end
    if (got.div_error !== want.div_error) begin
      errors++;
      $display("%0t: div_error expected %b actual %b", $time, want.div_error,
               got.div_error);
    end
    if (data[55:50] !== '0) begin
      errors++;
      $display("%0t: fill bits expected 0 actual %h", $time, data[55:50]);
    end
  endfunction
endclass

module tb_four_function_keypad_calculator;
  timeunit 1ns;
  timeprecision 1ps;
  import ffkc_pkg::*;

  localparam int LIMIT = 2_000_000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // kind[1:0], digit[5:2], op_code[7:6]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // display[47:0], overflow[48], div_error[49]

  ffkc_scoreboard calc_board;
  int send_idle_pct;   // chance per cycle that the key sender holds off
  int recv_stall_pct;  // chance per cycle that the result side stalls
  int cycles;
  int keys_sent;

  four_function_keypad_calculator uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb_four_function_keypad_calculator: errors");
        $finish;
      end
    end
  end

  // Result side: stall at random, check every completed transaction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) calc_board.check_result(m_axis_tdata);
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one key; idle at random first, then hold tvalid until accepted.
  // tvalid stays high after acceptance until an idle cycle or drain() drops it.
  task automatic send_key(kind_t kind, logic [3:0] dig, logic [1:0] opc);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {opc, dig, kind};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    calc_board.note_key(kind, dig, opc);
    keys_sent++;
  endtask

  task automatic send_digit(int d);
    send_key(KIND_DIGIT, 4'(d), 2'($urandom_range(3)));
  endtask

  task automatic send_op(op_t op);
    send_key(KIND_OP, 4'($urandom_range(15)), op[1:0]);
  endtask

  task automatic send_eq();
    send_key(KIND_EQ, 4'($urandom_range(15)), 2'($urandom_range(3)));
  endtask

  task automatic send_clear();
    send_key(KIND_CLEAR, 4'($urandom_range(15)), 2'($urandom_range(3)));
  endtask

  // Drop tvalid and hold off until every queued result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (calc_board.pending_q.size() != 0) @(posedge clk);
  endtask

  // A random number entry of 1..n digits.
  task automatic send_number(int n);
    int len;
    len = $urandom_range(n, 1);
    for (int i = 0; i < len; i++) send_digit($urandom_range(9));
  endtask

  // One random calculation: mostly well formed, with some noise.
  task automatic random_sequence();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_key(kind_t'($urandom_range(3)), 4'($urandom_range(15)),
               2'($urandom_range(3)));
    end else if (pick < 15) begin
      // long entry drives the display into saturation
      send_number(16);
    end else begin
      send_number(pick < 60 ? 3 : 7);
      send_op(op_t'($urandom_range(3)));
      if ($urandom_range(9) != 0) send_number($urandom_range(1) ? 2 : 6);
      send_eq();
      repeat ($urandom_range(3)) send_eq();
      if ($urandom_range(4) == 0) send_clear();
    end
  endtask

  initial begin
    int phase_keys;
    calc_board = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    keys_sent = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: equals with nothing set, digit extremes, each operator,
    // digit zero after an operator, bad digits, repeat equals, divide by zero.
    send_eq();
    send_digit(0);
    send_digit(9);
    send_key(KIND_DIGIT, 4'd15, 2'd3);
    send_key(KIND_DIGIT, 4'd10, 2'd0);
    send_op(OP_ADD);
    send_digit(0);
    send_digit(2);
    send_eq();
    send_eq();
    send_op(OP_SUB);
    send_digit(7);
    send_eq();
    send_eq();
    send_op(OP_MUL);
    send_digit(3);
    send_eq();
    send_eq();
    send_op(OP_DIV);
    send_digit(0);
    send_eq();
    send_clear();
    send_digit(8);
    send_op(OP_DIV);
    send_digit(3);
    send_eq();
    send_eq();
    send_clear();
    drain();

    // Random phases with different idling mixes.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 3 ? 24 : 76) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 24 : 76) : 0;
      phase_keys = keys_sent;
      while (keys_sent - phase_keys < 270) random_sequence();
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Covered %0d keys, %0d results checked, %0d saturations, %0d divides by zero.",
             keys_sent, calc_board.checked, calc_board.ovf_seen, calc_board.derr_seen);
    if (calc_board.errors == 0 && calc_board.pending_q.size() == 0) begin
      $display("tb_four_function_keypad_calculator: clean");
    end else begin
      $display("tb_four_function_keypad_calculator: errors");
    end
    $finish;
  end
endmodule
